// File: design/cofs_pkg.sv
// Shared types and constants for the CPU operand fetch sequencer.
// Item structs, addressing mode codes, result kinds and fetch phases.
// No dependencies.
`timescale 1ns / 1ps

package cofs_pkg;

    // Input item
    typedef struct packed {
        logic        func;
        logic [4:0]  mode;
        logic        first_is_reg_c;
        logic [15:0] first_reg_value;
        logic [15:0] second_reg_value;
        logic [15:0] hl_value;
        logic [15:0] pc_value;
        logic [7:0]  bus_byte;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] bus_address;
        logic [15:0] operand_data;
        logic [15:0] dest_address;
        logic        dest_in_memory;
        logic [15:0] next_pc;
        logic [15:0] next_hl;
        logic        hl_changed;
        logic [1:0]  bus_cycles;
    } t_out_item;

    // Item functions
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_REQ  = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Fetch phases: idle, or waiting for bus read 1..3
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_READ1 = 2'd1;
    localparam logic [1:0] PH_READ2 = 2'd2;
    localparam logic [1:0] PH_READ3 = 2'd3;

    // Addressing modes
    localparam logic [4:0] MODE_IMP    = 5'd0;
    localparam logic [4:0] MODE_R      = 5'd1;
    localparam logic [4:0] MODE_R_R    = 5'd2;
    localparam logic [4:0] MODE_R_D8   = 5'd3;
    localparam logic [4:0] MODE_R_D16  = 5'd4;
    localparam logic [4:0] MODE_D16    = 5'd5;
    localparam logic [4:0] MODE_MR_R   = 5'd6;
    localparam logic [4:0] MODE_R_MR   = 5'd7;
    localparam logic [4:0] MODE_R_HLI  = 5'd8;
    localparam logic [4:0] MODE_HLI_R  = 5'd9;
    localparam logic [4:0] MODE_HLD_R  = 5'd10;
    localparam logic [4:0] MODE_R_HLD  = 5'd11;
    localparam logic [4:0] MODE_R_A8   = 5'd12;
    localparam logic [4:0] MODE_A8_R   = 5'd13;
    localparam logic [4:0] MODE_HL_SPR = 5'd14;
    localparam logic [4:0] MODE_D8     = 5'd15;
    localparam logic [4:0] MODE_A16_R  = 5'd16;
    localparam logic [4:0] MODE_D16_R  = 5'd17;
    localparam logic [4:0] MODE_MR_D8  = 5'd18;
    localparam logic [4:0] MODE_MR     = 5'd19;
    localparam logic [4:0] MODE_R_A16  = 5'd20;

    // High page base for 8-bit I/O addressing
    localparam logic [15:0] HIGH_PAGE = 16'hFF00;

endpackage

// File: design/cofs_exec.sv
// Fetch sequencer core: held fetch context, phase register and result logic.
// Depends on cofs_pkg for item types, mode codes and phase codes.
`timescale 1ns / 1ps

module cofs_exec (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  cofs_pkg::t_in_item    i_item,
    output cofs_pkg::t_out_item   o_result
);

    logic [1:0]  r_phase, n_phase;
    logic [4:0]  r_mode, n_mode;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_first, n_first;
    logic [15:0] r_second, n_second;
    logic [15:0] r_hl, n_hl;
    logic        r_is_c, n_is_c;
    logic [15:0] r_last, n_last;

    logic [15:0] w_hp;
    logic [15:0] w_pc1;
    logic [15:0] w_pc2;
    logic [15:0] w_word;
    logic [7:0]  w_b;
    cofs_pkg::t_out_item w_res;

    // Helpers for the data path of a pending fetch
    assign w_b    = i_item.bus_byte;
    assign w_pc1  = r_pc + 16'd1;
    assign w_pc2  = r_pc + 16'd2;
    assign w_word = {w_b, r_low};
    assign w_hp   = i_item.first_is_reg_c ? cofs_pkg::HIGH_PAGE : 16'h0000;

    // Next state and result for the item at hand
    always_comb begin
        n_phase  = r_phase;
        n_mode   = r_mode;
        n_pc     = r_pc;
        n_low    = r_low;
        n_first  = r_first;
        n_second = r_second;
        n_hl     = r_hl;
        n_is_c   = r_is_c;
        n_last   = r_last;
        w_res      = '0;
        w_res.kind = cofs_pkg::KIND_ERR;

        if (i_item.func == cofs_pkg::FUNC_START) begin
            if (r_phase != cofs_pkg::PH_IDLE) begin
                // start over a pending fetch: abandon it
                n_phase = cofs_pkg::PH_IDLE;
            end else begin
                n_mode   = i_item.mode;
                n_is_c   = i_item.first_is_reg_c;
                n_first  = i_item.first_reg_value;
                n_second = i_item.second_reg_value;
                n_hl     = i_item.hl_value;
                n_pc     = i_item.pc_value;
                w_res.next_pc = i_item.pc_value;
                w_res.next_hl = i_item.hl_value;
                unique case (i_item.mode)
                    cofs_pkg::MODE_IMP: begin
                        w_res.kind         = cofs_pkg::KIND_DONE;
                        w_res.operand_data = r_last;
                    end
                    cofs_pkg::MODE_R: begin
                        w_res.kind         = cofs_pkg::KIND_DONE;
                        w_res.operand_data = i_item.first_reg_value;
                        n_last             = i_item.first_reg_value;
                    end
                    cofs_pkg::MODE_R_R: begin
                        w_res.kind         = cofs_pkg::KIND_DONE;
                        w_res.operand_data = i_item.second_reg_value;
                        n_last             = i_item.second_reg_value;
                    end
                    cofs_pkg::MODE_MR_R: begin
                        w_res.kind           = cofs_pkg::KIND_DONE;
                        w_res.operand_data   = i_item.second_reg_value;
                        w_res.dest_address   = i_item.first_reg_value | w_hp;
                        w_res.dest_in_memory = 1'b1;
                        n_last               = i_item.second_reg_value;
                    end
                    cofs_pkg::MODE_HLI_R, cofs_pkg::MODE_HLD_R: begin
                        w_res.kind           = cofs_pkg::KIND_DONE;
                        w_res.operand_data   = i_item.second_reg_value;
                        w_res.dest_address   = i_item.first_reg_value;
                        w_res.dest_in_memory = 1'b1;
                        w_res.hl_changed     = 1'b1;
                        w_res.next_hl        = (i_item.mode == cofs_pkg::MODE_HLI_R)
                                             ? i_item.hl_value + 16'd1
                                             : i_item.hl_value - 16'd1;
                        n_last               = i_item.second_reg_value;
                    end
                    cofs_pkg::MODE_R_MR: begin
                        w_res         = '0;
                        w_res.kind    = cofs_pkg::KIND_REQ;
                        w_res.bus_address = i_item.second_reg_value | w_hp;
                        n_phase       = cofs_pkg::PH_READ1;
                    end
                    cofs_pkg::MODE_R_HLI, cofs_pkg::MODE_R_HLD: begin
                        w_res         = '0;
                        w_res.kind    = cofs_pkg::KIND_REQ;
                        w_res.bus_address = i_item.second_reg_value;
                        n_phase       = cofs_pkg::PH_READ1;
                    end
                    cofs_pkg::MODE_MR: begin
                        w_res         = '0;
                        w_res.kind    = cofs_pkg::KIND_REQ;
                        w_res.bus_address = i_item.first_reg_value;
                        n_phase       = cofs_pkg::PH_READ1;
                    end
                    cofs_pkg::MODE_R_D8, cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16,
                    cofs_pkg::MODE_R_A8, cofs_pkg::MODE_A8_R, cofs_pkg::MODE_HL_SPR,
                    cofs_pkg::MODE_D8, cofs_pkg::MODE_A16_R, cofs_pkg::MODE_D16_R,
                    cofs_pkg::MODE_MR_D8, cofs_pkg::MODE_R_A16: begin
                        w_res         = '0;
                        w_res.kind    = cofs_pkg::KIND_REQ;
                        w_res.bus_address = i_item.pc_value;
                        n_phase       = cofs_pkg::PH_READ1;
                    end
                    default: begin
                        // unknown mode: error, stay idle
                        w_res      = '0;
                        w_res.kind = cofs_pkg::KIND_ERR;
                    end
                endcase
            end
        end else if (r_phase != cofs_pkg::PH_IDLE) begin
            // bus data for a pending read; anything unexpected is an error
            n_phase       = cofs_pkg::PH_IDLE;
            w_res.next_pc = r_pc;
            w_res.next_hl = r_hl;
            w_res.kind    = cofs_pkg::KIND_DONE;
            unique case (r_phase)
                cofs_pkg::PH_READ1: begin
                    w_res.bus_cycles   = 2'd1;
                    w_res.operand_data = {8'h00, w_b};
                    n_last             = {8'h00, w_b};
                    unique case (r_mode)
                        cofs_pkg::MODE_R_D8, cofs_pkg::MODE_R_A8,
                        cofs_pkg::MODE_HL_SPR, cofs_pkg::MODE_D8: begin
                            w_res.next_pc = w_pc1;
                        end
                        cofs_pkg::MODE_R_MR: begin
                            w_res.next_pc = r_pc;
                        end
                        cofs_pkg::MODE_R_HLI: begin
                            w_res.next_hl    = r_hl + 16'd1;
                            w_res.hl_changed = 1'b1;
                        end
                        cofs_pkg::MODE_R_HLD: begin
                            w_res.next_hl    = r_hl - 16'd1;
                            w_res.hl_changed = 1'b1;
                        end
                        cofs_pkg::MODE_A8_R: begin
                            w_res.operand_data   = r_last;
                            n_last               = r_last;
                            w_res.dest_address   = {8'h00, w_b} | cofs_pkg::HIGH_PAGE;
                            w_res.dest_in_memory = 1'b1;
                            w_res.next_pc        = w_pc1;
                        end
                        cofs_pkg::MODE_MR_D8: begin
                            w_res.dest_address   = r_first;
                            w_res.dest_in_memory = 1'b1;
                            w_res.next_pc        = w_pc1;
                        end
                        cofs_pkg::MODE_MR: begin
                            w_res.dest_address   = r_first;
                            w_res.dest_in_memory = 1'b1;
                        end
                        cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16, cofs_pkg::MODE_A16_R,
                        cofs_pkg::MODE_D16_R, cofs_pkg::MODE_R_A16: begin
                            // low immediate byte; go fetch the high byte
                            w_res             = '0;
                            w_res.kind        = cofs_pkg::KIND_REQ;
                            w_res.bus_address = w_pc1;
                            n_last            = r_last;
                            n_low             = w_b;
                            n_phase           = cofs_pkg::PH_READ2;
                        end
                        default: begin
                            w_res      = '0;
                            w_res.kind = cofs_pkg::KIND_ERR;
                            n_last     = r_last;
                        end
                    endcase
                end
                cofs_pkg::PH_READ2: begin
                    w_res.bus_cycles = 2'd2;
                    w_res.next_pc    = w_pc2;
                    unique case (r_mode)
                        cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16: begin
                            w_res.operand_data = w_word;
                            n_last             = w_word;
                        end
                        cofs_pkg::MODE_A16_R, cofs_pkg::MODE_D16_R: begin
                            w_res.operand_data   = r_second;
                            w_res.dest_address   = w_word;
                            w_res.dest_in_memory = 1'b1;
                            n_last               = r_second;
                        end
                        cofs_pkg::MODE_R_A16: begin
                            // 16-bit address assembled; read through it
                            w_res             = '0;
                            w_res.kind        = cofs_pkg::KIND_REQ;
                            w_res.bus_address = w_word;
                            n_phase           = cofs_pkg::PH_READ3;
                        end
                        default: begin
                            w_res      = '0;
                            w_res.kind = cofs_pkg::KIND_ERR;
                        end
                    endcase
                end
                cofs_pkg::PH_READ3: begin
                    if (r_mode == cofs_pkg::MODE_R_A16) begin
                        w_res.bus_cycles   = 2'd3;
                        w_res.next_pc      = w_pc2;
                        w_res.operand_data = {8'h00, w_b};
                        n_last             = {8'h00, w_b};
                    end else begin
                        w_res      = '0;
                        w_res.kind = cofs_pkg::KIND_ERR;
                    end
                end
                default: begin
                    w_res      = '0;
                    w_res.kind = cofs_pkg::KIND_ERR;
                end
            endcase
        end
        // data while idle: error, state unchanged (defaults)
    end

    assign o_result = w_res;

    // Fetch context and phase registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= cofs_pkg::PH_IDLE;
            r_mode   <= 5'd0;
            r_pc     <= 16'd0;
            r_low    <= 8'd0;
            r_first  <= 16'd0;
            r_second <= 16'd0;
            r_hl     <= 16'd0;
            r_is_c   <= 1'b0;
            r_last   <= 16'd0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_mode   <= n_mode;
            r_pc     <= n_pc;
            r_low    <= n_low;
            r_first  <= n_first;
            r_second <= n_second;
            r_hl     <= n_hl;
            r_is_c   <= n_is_c;
            r_last   <= n_last;
        end
    end

endmodule

// File: design/cpu_operand_fetch_sequencer.sv
// Top level of the CPU operand fetch sequencer: input and result registers.
// Depends on cofs_pkg and cofs_exec.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes start items
//   and bus-data items. Every input item gives exactly one result item on
//   the output channel (o_out_valid / i_out_stall / o_out_data): a bus read
//   request, a completed fetch, or an error.
//   A start item either completes at once or yields a request; each request
//   is answered by a bus-data item that yields the next request or the
//   completed fetch (up to three reads per fetch).
//   An accepted item is held in the input register; its result is
//   registered in the result register and then valid on the output.
//   Throughput: one item per cycle while the receiver does not stall; the
//   input register and the result register each hold one item, with a
//   single pass of mux and 16-bit increment logic between them.
//   When the receiver stalls, the result holds, the pending input item
//   holds in the input register, and o_in_stall rises once both are full.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   sequencer to idle with all held context and the last operand at zero.
`timescale 1ns / 1ps

module cpu_operand_fetch_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cofs_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cofs_pkg::t_out_item   o_out_data
);

    logic                r_in_valid;
    cofs_pkg::t_in_item  r_in;
    logic                r_out_valid;
    cofs_pkg::t_out_item r_out;
    cofs_pkg::t_out_item w_result;
    logic                w_advance;
    logic                w_go;

    // Result register can take a new item unless it holds a stalled one
    assign w_advance  = !(r_out_valid && i_out_stall);
    assign w_go       = w_advance && r_in_valid;
    assign o_in_stall = r_in_valid && !w_advance;

    cofs_exec u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_item   (r_in),
        .o_result (w_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: verif/cpu_operand_fetch_sequencer_test.sv
// Self-checking testbench for cpu_operand_fetch_sequencer.
// Drives start and bus-data items, predicts every result item and checks it.
// Depends on cofs_pkg and the design top level.
`timescale 1ns / 1ps

module cpu_operand_fetch_sequencer_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 400;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    cofs_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    cofs_pkg::t_out_item o_out_data;

    // Predicted sequencer context
    logic [1:0]  ctx_phase;
    logic [4:0]  ctx_mode;
    logic [15:0] ctx_pc;
    logic [7:0]  ctx_low;
    logic [15:0] ctx_first;
    logic [15:0] ctx_second;
    logic [15:0] ctx_hl;
    logic        ctx_is_c;
    logic [15:0] ctx_last;

    cofs_pkg::t_out_item fetch_results_due[$];
    int          fail_count;
    int          items_sent;
    int          cycle_count;
    int          stall_left;
    bit          idle_enable;

    cpu_operand_fetch_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Completed fetch: back to idle, remember the operand
    function automatic cofs_pkg::t_out_item fetch_done(input logic [15:0] op,
                                                       input logic [15:0] dest,
                                                       input logic mem, input logic [15:0] pc,
                                                       input logic [15:0] hl, input logic hlc,
                                                       input logic [1:0] cycles);
        cofs_pkg::t_out_item r;
        ctx_phase = cofs_pkg::PH_IDLE;
        ctx_last = op;
        r = '0;
        r.kind = cofs_pkg::KIND_DONE;
        r.operand_data = op;
        r.dest_address = mem ? dest : 16'h0000;
        r.dest_in_memory = mem;
        r.next_pc = pc;
        r.next_hl = hl;
        r.hl_changed = hlc;
        r.bus_cycles = cycles;
        return r;
    endfunction

    function automatic cofs_pkg::t_out_item bus_request(input logic [15:0] addr,
                                                        input logic [1:0] next_phase);
        cofs_pkg::t_out_item r;
        ctx_phase = next_phase;
        r = '0;
        r.kind = cofs_pkg::KIND_REQ;
        r.bus_address = addr;
        return r;
    endfunction

    // One step of the sequencer; errors leave the result at its default
    function automatic cofs_pkg::t_out_item predict_fetch_step(input cofs_pkg::t_in_item it);
        cofs_pkg::t_out_item r;
        logic [1:0]  was_phase;
        logic [15:0] hp;
        logic [15:0] pc1;
        logic [15:0] pc2;
        logic [15:0] word;
        logic [15:0] b16;
        r = '0;
        r.kind = cofs_pkg::KIND_ERR;
        was_phase = ctx_phase;
        if (it.func == cofs_pkg::FUNC_START) begin
            ctx_phase = cofs_pkg::PH_IDLE;
            // start while a fetch is pending abandons it
            if (was_phase != cofs_pkg::PH_IDLE) return r;
            ctx_mode = it.mode;
            ctx_is_c = it.first_is_reg_c;
            ctx_first = it.first_reg_value;
            ctx_second = it.second_reg_value;
            ctx_hl = it.hl_value;
            ctx_pc = it.pc_value;
            hp = ctx_is_c ? cofs_pkg::HIGH_PAGE : 16'h0000;
            case (ctx_mode)
                cofs_pkg::MODE_IMP:
                    r = fetch_done(ctx_last, 16'h0, 1'b0, ctx_pc, ctx_hl, 1'b0, 2'd0);
                cofs_pkg::MODE_R:
                    r = fetch_done(ctx_first, 16'h0, 1'b0, ctx_pc, ctx_hl, 1'b0, 2'd0);
                cofs_pkg::MODE_R_R:
                    r = fetch_done(ctx_second, 16'h0, 1'b0, ctx_pc, ctx_hl, 1'b0, 2'd0);
                cofs_pkg::MODE_MR_R:
                    r = fetch_done(ctx_second, ctx_first | hp, 1'b1, ctx_pc, ctx_hl,
                                   1'b0, 2'd0);
                cofs_pkg::MODE_HLI_R:
                    r = fetch_done(ctx_second, ctx_first, 1'b1, ctx_pc,
                                   ctx_hl + 16'd1, 1'b1, 2'd0);
                cofs_pkg::MODE_HLD_R:
                    r = fetch_done(ctx_second, ctx_first, 1'b1, ctx_pc,
                                   ctx_hl - 16'd1, 1'b1, 2'd0);
                cofs_pkg::MODE_R_MR:
                    r = bus_request(ctx_second | hp, cofs_pkg::PH_READ1);
                cofs_pkg::MODE_R_HLI, cofs_pkg::MODE_R_HLD:
                    r = bus_request(ctx_second, cofs_pkg::PH_READ1);
                cofs_pkg::MODE_MR:
                    r = bus_request(ctx_first, cofs_pkg::PH_READ1);
                cofs_pkg::MODE_R_D8, cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16,
                cofs_pkg::MODE_R_A8, cofs_pkg::MODE_A8_R, cofs_pkg::MODE_HL_SPR,
                cofs_pkg::MODE_D8, cofs_pkg::MODE_A16_R, cofs_pkg::MODE_D16_R,
                cofs_pkg::MODE_MR_D8, cofs_pkg::MODE_R_A16:
                    r = bus_request(ctx_pc, cofs_pkg::PH_READ1);
                default: ;
            endcase
            return r;
        end
        // stray data while idle: state untouched
        if (was_phase == cofs_pkg::PH_IDLE) return r;
        ctx_phase = cofs_pkg::PH_IDLE;
        pc1 = ctx_pc + 16'd1;
        pc2 = ctx_pc + 16'd2;
        word = {it.bus_byte, ctx_low};
        b16 = {8'h00, it.bus_byte};
        case (was_phase)
            cofs_pkg::PH_READ1: begin
                case (ctx_mode)
                    cofs_pkg::MODE_R_D8, cofs_pkg::MODE_R_A8, cofs_pkg::MODE_HL_SPR,
                    cofs_pkg::MODE_D8:
                        r = fetch_done(b16, 16'h0, 1'b0, pc1, ctx_hl, 1'b0, 2'd1);
                    cofs_pkg::MODE_R_MR:
                        r = fetch_done(b16, 16'h0, 1'b0, ctx_pc, ctx_hl, 1'b0, 2'd1);
                    cofs_pkg::MODE_R_HLI:
                        r = fetch_done(b16, 16'h0, 1'b0, ctx_pc, ctx_hl + 16'd1,
                                       1'b1, 2'd1);
                    cofs_pkg::MODE_R_HLD:
                        r = fetch_done(b16, 16'h0, 1'b0, ctx_pc, ctx_hl - 16'd1,
                                       1'b1, 2'd1);
                    cofs_pkg::MODE_A8_R:
                        r = fetch_done(ctx_last, b16 | cofs_pkg::HIGH_PAGE, 1'b1, pc1,
                                       ctx_hl, 1'b0, 2'd1);
                    cofs_pkg::MODE_MR_D8:
                        r = fetch_done(b16, ctx_first, 1'b1, pc1, ctx_hl, 1'b0, 2'd1);
                    cofs_pkg::MODE_MR:
                        r = fetch_done(b16, ctx_first, 1'b1, ctx_pc, ctx_hl, 1'b0, 2'd1);
                    cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16, cofs_pkg::MODE_A16_R,
                    cofs_pkg::MODE_D16_R, cofs_pkg::MODE_R_A16: begin
                        ctx_low = it.bus_byte;
                        r = bus_request(pc1, cofs_pkg::PH_READ2);
                    end
                    default: ;
                endcase
            end
            cofs_pkg::PH_READ2: begin
                case (ctx_mode)
                    cofs_pkg::MODE_R_D16, cofs_pkg::MODE_D16:
                        r = fetch_done(word, 16'h0, 1'b0, pc2, ctx_hl, 1'b0, 2'd2);
                    cofs_pkg::MODE_A16_R, cofs_pkg::MODE_D16_R:
                        r = fetch_done(ctx_second, word, 1'b1, pc2, ctx_hl, 1'b0, 2'd2);
                    cofs_pkg::MODE_R_A16:
                        r = bus_request(word, cofs_pkg::PH_READ3);
                    default: ;
                endcase
            end
            cofs_pkg::PH_READ3: begin
                if (ctx_mode == cofs_pkg::MODE_R_A16)
                    r = fetch_done(b16, 16'h0, 1'b0, pc2, ctx_hl, 1'b0, 2'd3);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Item builders; unused fields carry random content
    function automatic cofs_pkg::t_in_item start_item(input logic [4:0] mode, input logic is_c,
                                                      input logic [15:0] first,
                                                      input logic [15:0] second,
                                                      input logic [15:0] hl,
                                                      input logic [15:0] pc);
        cofs_pkg::t_in_item it;
        it.func = cofs_pkg::FUNC_START;
        it.mode = mode;
        it.first_is_reg_c = is_c;
        it.first_reg_value = first;
        it.second_reg_value = second;
        it.hl_value = hl;
        it.pc_value = pc;
        it.bus_byte = 8'($urandom);
        return it;
    endfunction

    function automatic cofs_pkg::t_in_item random_item();
        cofs_pkg::t_in_item it;
        it = start_item(5'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
        it.func = 1'($urandom);
        return it;
    endfunction

    function automatic cofs_pkg::t_in_item data_item(input logic [7:0] b);
        cofs_pkg::t_in_item it;
        it = random_item();
        it.func = cofs_pkg::FUNC_DATA;
        it.bus_byte = b;
        return it;
    endfunction

    // Random start item over the valid modes
    function automatic cofs_pkg::t_in_item random_start();
        return start_item(5'($urandom_range(cofs_pkg::MODE_IMP, cofs_pkg::MODE_R_A16)),
                          1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
    endfunction

    // Send one item after an optional idle burst; predict at acceptance
    task automatic issue_item(input cofs_pkg::t_in_item it);
        int gap;
        gap = (idle_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fetch_results_due.push_back(predict_fetch_step(it));
        items_sent++;
    endtask

    // A whole fetch: start, then data items until the sequencer goes idle.
    // A broken fetch may get a random item in place of a bus byte.
    task automatic run_fetch(input cofs_pkg::t_in_item start, input bit broken);
        issue_item(start);
        while (ctx_phase != cofs_pkg::PH_IDLE) begin
            if (broken && $urandom_range(0, 2) == 0)
                issue_item(random_item());
            else
                issue_item(data_item(8'($urandom)));
        end
    endtask

    // Hold off the sender until every result has come, plus the pipeline latency
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (fetch_results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic test_after_reset();
        // stray data while idle, then implied mode sees the cleared operand
        issue_item(data_item(8'hA5));
        issue_item(start_item(cofs_pkg::MODE_IMP, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF));
    endtask

    task automatic test_each_mode();
        int m;
        for (m = int'(cofs_pkg::MODE_IMP); m <= int'(cofs_pkg::MODE_R_A16); m++)
            run_fetch(start_item(5'(m), m[0], 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom)), 1'b0);
        issue_item(start_item(cofs_pkg::MODE_IMP, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0));
    endtask

    task automatic test_wraparound();
        // 16-bit immediate read across the top of memory
        issue_item(start_item(cofs_pkg::MODE_R_D16, 1'b0, 16'h1234, 16'h5678, 16'h0000,
                              16'hFFFF));
        issue_item(data_item(8'h00));
        issue_item(data_item(8'hFF));
        // three-read fetch with PC+2 wrapping
        issue_item(start_item(cofs_pkg::MODE_R_A16, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF,
                              16'hFFFE));
        issue_item(data_item(8'hFF));
        issue_item(data_item(8'hFF));
        issue_item(data_item(8'h00));
        // HL increment and decrement wrapping
        issue_item(start_item(cofs_pkg::MODE_HLI_R, 1'b0, 16'hFFFF, 16'h00FF, 16'hFFFF,
                              16'h0000));
        issue_item(start_item(cofs_pkg::MODE_HLD_R, 1'b1, 16'h0000, 16'hFF00, 16'h0000,
                              16'hFFFF));
        issue_item(start_item(cofs_pkg::MODE_R_HLI, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF,
                              16'h0000));
        issue_item(data_item(8'hFF));
        issue_item(start_item(cofs_pkg::MODE_R_HLD, 1'b0, 16'hFFFF, 16'h0000, 16'h0000,
                              16'hFFFF));
        issue_item(data_item(8'h00));
        // high page through register C
        issue_item(start_item(cofs_pkg::MODE_R_MR, 1'b1, 16'h0000, 16'h00FF, 16'h0000,
                              16'h0000));
        issue_item(data_item(8'h80));
        issue_item(start_item(cofs_pkg::MODE_MR_R, 1'b1, 16'h00FF, 16'hFFFF, 16'h0000,
                              16'h0000));
        issue_item(start_item(cofs_pkg::MODE_A8_R, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                              16'hFFFF));
        issue_item(data_item(8'hFF));
    endtask

    task automatic test_protocol_errors();
        // start while pending: error, new start dropped, then stray data
        issue_item(start_item(cofs_pkg::MODE_R_D8, 1'b0, 16'h0001, 16'h0002, 16'h0003,
                              16'h0004));
        issue_item(start_item(cofs_pkg::MODE_R, 1'b0, 16'hBEEF, 16'h0000, 16'h0000,
                              16'h0000));
        issue_item(data_item(8'h11));
        // abandon a two-read fetch half way
        issue_item(start_item(cofs_pkg::MODE_D16_R, 1'b0, 16'h0000, 16'h1111, 16'h2222,
                              16'h3333));
        issue_item(data_item(8'h44));
        issue_item(start_item(cofs_pkg::MODE_IMP, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                              16'h0000));
        // invalid modes
        issue_item(start_item(5'd21, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        issue_item(start_item(5'd31, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_random_fetches(input int target);
        int stop_at;
        int next_toggle;
        int pick;
        cofs_pkg::t_in_item it;
        stop_at = items_sent + target;
        next_toggle = items_sent;
        while (items_sent < stop_at) begin
            // stretches with and without idling
            if (items_sent >= next_toggle) begin
                idle_enable = ($urandom_range(0, 3) != 0);
                next_toggle = items_sent + 40;
            end
            pick = $urandom_range(0, 9);
            it = random_start();
            if (pick < 8)
                run_fetch(it, 1'b0);
            else if (pick == 8)
                issue_item(random_item());
            else
                run_fetch(it, 1'b1);
        end
    endtask

    task automatic test_back_to_back();
        int n;
        idle_enable = 1'b0;
        for (n = 0; n < 15; n++)
            run_fetch(random_start(), 1'b0);
    endtask

    // Receiver stall bursts
    initial begin
        i_out_stall = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (!idle_enable) begin
                stall_left = 0;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        cofs_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fetch_results_due.size() == 0) begin
                $error("result item with nothing expected: %h", o_out_data);
                fail_count++;
            end else begin
                want = fetch_results_due.pop_front();
                check_field("kind", 16'(want.kind), 16'(o_out_data.kind));
                check_field("bus_address", want.bus_address, o_out_data.bus_address);
                check_field("operand_data", want.operand_data, o_out_data.operand_data);
                check_field("dest_address", want.dest_address, o_out_data.dest_address);
                check_field("dest_in_memory", 16'(want.dest_in_memory),
                            16'(o_out_data.dest_in_memory));
                check_field("next_pc", want.next_pc, o_out_data.next_pc);
                check_field("next_hl", want.next_hl, o_out_data.next_hl);
                check_field("hl_changed", 16'(want.hl_changed), 16'(o_out_data.hl_changed));
                check_field("bus_cycles", 16'(want.bus_cycles), 16'(o_out_data.bus_cycles));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        fail_count = 0;
        items_sent = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        ctx_phase = cofs_pkg::PH_IDLE;
        ctx_mode = cofs_pkg::MODE_IMP;
        ctx_pc = '0;
        ctx_low = '0;
        ctx_first = '0;
        ctx_second = '0;
        ctx_hl = '0;
        ctx_is_c = 1'b0;
        ctx_last = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_each_mode();
        wait_for_drain();
        test_wraparound();
        test_protocol_errors();
        wait_for_drain();
        test_random_fetches(RANDOM_ITEMS);
        test_back_to_back();
        wait_for_drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
design/cofs_pkg.sv
design/cofs_exec.sv
design/cpu_operand_fetch_sequencer.sv
verif/cpu_operand_fetch_sequencer_test.sv
